@@ rtl/sfgd_pkg.sv @@
package sfgd_pkg;

	localparam int unsigned ACCEL_W  = 16;
	localparam int unsigned THRESH_W = 16;
	localparam int unsigned HOLD_W   = 32;
	localparam int unsigned TICK_W   = 16;
	localparam int unsigned CLOCK_W  = 32;
	localparam int unsigned APB_DW   = 32;
	localparam int unsigned APB_AW   = 4;

	localparam logic [THRESH_W-1:0] SHAKE_LIMIT_RST = 16'd500;
	localparam logic [HOLD_W-1:0]   HOLD_TIME_RST   = 32'd2000;
	localparam logic [TICK_W-1:0]   TICK_RST        = 16'd100;

	// Register index, taken from paddr[3:2]
	typedef enum logic [1:0] {
		REG_SHAKE_LIMIT = 2'd0,
		REG_HOLD_TIME   = 2'd1,
		REG_TICK        = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [THRESH_W-1:0] shake_limit;
		logic [HOLD_W-1:0]   hold_time_ms;
		logic [TICK_W-1:0]   tick_ms;
	} cfg_t;

	typedef struct packed {
		logic signed [ACCEL_W-1:0] accel_x;
		logic signed [ACCEL_W-1:0] accel_y;
		logic signed [ACCEL_W-1:0] accel_z;
		logic                      detect_active;
	} sample_t;

	typedef struct packed {
		logic shake_event;
		logic flip_event;
	} events_t;

endpackage

@@ rtl/sfgd_core.sv @@
module sfgd_core import sfgd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    advance,
	input  sample_t sample,
	input  cfg_t    cfg,
	output events_t events
);

	logic signed [ACCEL_W-1:0] prev_x_q, prev_y_q, prev_z_q;
	logic                      shake_latched_q;
	logic                      flip_waiting_q;
	logic [CLOCK_W-1:0]        flip_start_q;
	logic [CLOCK_W-1:0]        clock_q;

	logic signed [ACCEL_W-1:0] prev_x_d, prev_y_d, prev_z_d;
	logic                      shake_latched_d;
	logic                      flip_waiting_d;
	logic [CLOCK_W-1:0]        flip_start_d;
	logic [CLOCK_W-1:0]        clock_d;
	logic [CLOCK_W-1:0]        elapsed;
	logic                      over_x, over_y, over_z, shaking;

	// Full-precision absolute change compared against the threshold
	function automatic logic over_thresh(
		input logic signed [ACCEL_W-1:0] a,
		input logic signed [ACCEL_W-1:0] b,
		input logic [THRESH_W-1:0]       thr
	);
		logic signed [ACCEL_W:0] diff;
		logic [ACCEL_W:0]        mag;
		diff = {a[ACCEL_W-1], a} - {b[ACCEL_W-1], b};
		mag  = diff[ACCEL_W] ? (~diff + 1'b1) : diff;
		return mag > {{(ACCEL_W + 1 - THRESH_W){1'b0}}, thr};
	endfunction

	assign clock_d = clock_q + {{(CLOCK_W - TICK_W){1'b0}}, cfg.tick_ms};
	assign elapsed = clock_d - flip_start_q;
	assign over_x  = over_thresh(sample.accel_x, prev_x_q, cfg.shake_limit);
	assign over_y  = over_thresh(sample.accel_y, prev_y_q, cfg.shake_limit);
	assign over_z  = over_thresh(sample.accel_z, prev_z_q, cfg.shake_limit);
	assign shaking = over_x | over_y | over_z;

	// Evaluate one sample against the held state
	always_comb begin
		prev_x_d        = prev_x_q;
		prev_y_d        = prev_y_q;
		prev_z_d        = prev_z_q;
		shake_latched_d = shake_latched_q;
		flip_waiting_d  = flip_waiting_q;
		flip_start_d    = flip_start_q;
		events          = '0;
		if (sample.detect_active) begin
			events.shake_event = shaking & ~shake_latched_q;
			shake_latched_d    = shaking;
			if (sample.accel_z[ACCEL_W-1]) begin
				if (!flip_waiting_q) begin
					flip_waiting_d = 1'b1;
					flip_start_d   = clock_d;
				end else if (elapsed >= cfg.hold_time_ms) begin
					events.flip_event = 1'b1;
					flip_waiting_d    = 1'b0;
				end
			end else begin
				flip_waiting_d = 1'b0;
				flip_start_d   = '0;
			end
			prev_x_d = sample.accel_x;
			prev_y_d = sample.accel_y;
			prev_z_d = sample.accel_z;
		end
	end

	// Commit state when the item moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q        <= '0;
			prev_y_q        <= '0;
			prev_z_q        <= '0;
			shake_latched_q <= 1'b0;
			flip_waiting_q  <= 1'b0;
			flip_start_q    <= '0;
			clock_q         <= '0;
		end else if (advance) begin
			prev_x_q        <= prev_x_d;
			prev_y_q        <= prev_y_d;
			prev_z_q        <= prev_z_d;
			shake_latched_q <= shake_latched_d;
			flip_waiting_q  <= flip_waiting_d;
			flip_start_q    <= flip_start_d;
			clock_q         <= clock_d;
		end
	end

endmodule

@@ rtl/shake_and_flip_gesture_detector.sv @@
// Channel   Handshake              Payload
// in        in_valid / in_stall    accel_x, accel_y, accel_z, detect_active
// out       out_valid / out_stall  shake_event, flip_event
// cfg       APB write/read         shake_limit @0, hold_time_ms @4, tick_ms @8
//
// One item per cycle sustained while out_stall is low; an item is registered in
// the input register, then its result in the result register, which offers it
// on out_valid.
// The single subtract-compare pass over the held state lies between the two.
// arst_n clears valids, gesture state and loads register defaults.
// A stalled result holds; the input register then fills and in_stall rises.
module shake_and_flip_gesture_detector import sfgd_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [ACCEL_W-1:0] accel_x,
	input  logic signed [ACCEL_W-1:0] accel_y,
	input  logic signed [ACCEL_W-1:0] accel_z,
	input  logic                      detect_active,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      shake_event,
	output logic                      flip_event,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [APB_AW-1:0]         paddr,
	input  logic [APB_DW-1:0]         pwdata,
	output logic [APB_DW-1:0]         prdata,
	output logic                      pready
);

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     cfg_wr;

	sample_t  sample_s1;
	logic     valid_s1;
	events_t  result_q;
	logic     result_valid_q;
	events_t  events;
	logic     out_free, advance, in_take;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel & penable & pwrite & pready;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.shake_limit  <= SHAKE_LIMIT_RST;
			cfg_q.hold_time_ms <= HOLD_TIME_RST;
			cfg_q.tick_ms      <= TICK_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_SHAKE_LIMIT: cfg_q.shake_limit  <= pwdata[THRESH_W-1:0];
				REG_HOLD_TIME:   cfg_q.hold_time_ms <= pwdata[HOLD_W-1:0];
				REG_TICK:        cfg_q.tick_ms      <= pwdata[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		unique case (reg_idx)
			REG_SHAKE_LIMIT:
				prdata = {{(APB_DW - THRESH_W){1'b0}}, cfg_q.shake_limit};
			REG_HOLD_TIME:
				prdata = cfg_q.hold_time_ms;
			REG_TICK:
				prdata = {{(APB_DW - TICK_W){1'b0}}, cfg_q.tick_ms};
			default:
				prdata = '0;
		endcase
	end

	// Pipeline flow
	assign out_free = ~result_valid_q | ~out_stall;
	assign advance  = valid_s1 & out_free;
	assign in_stall = valid_s1 & ~out_free;
	assign in_take  = in_valid & ~in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			sample_s1.accel_x       <= accel_x;
			sample_s1.accel_y       <= accel_y;
			sample_s1.accel_z       <= accel_z;
			sample_s1.detect_active <= detect_active;
		end
	end

	sfgd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(advance),
		.sample (sample_s1),
		.cfg    (cfg_q),
		.events (events)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_free) begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= events;
		end
	end

	assign out_valid   = result_valid_q;
	assign shake_event = result_q.shake_event;
	assign flip_event  = result_q.flip_event;

endmodule
